// ===== src/dattc_pkg.sv =====
// Shared types, register offsets and CRC helper for the disk adapter timer/transfer core.
// No dependencies; every other file imports this package.

package dattc_pkg;

	localparam int POSITION_BITS_DEF = 16;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	localparam logic [4:0] REG_RELOAD_LO = 5'h00;
	localparam logic [4:0] REG_RELOAD_HI = 5'h01;
	localparam logic [4:0] REG_TIMER_CTL = 5'h02;
	localparam logic [4:0] REG_ENABLE    = 5'h03;
	localparam logic [4:0] REG_WDATA     = 5'h04;
	localparam logic [4:0] REG_CONTROL   = 5'h05;
	localparam logic [4:0] REG_EXT_OUT   = 5'h06;
	localparam logic [4:0] REG_STATUS    = 5'h10;
	localparam logic [4:0] REG_RDATA     = 5'h11;
	localparam logic [4:0] REG_DRIVE     = 5'h12;
	localparam logic [4:0] REG_EXT_IN    = 5'h13;

	localparam logic [1:0] CFG_INSERTED   = 2'd0;
	localparam logic [1:0] CFG_SIDE_LEN   = 2'd1;
	localparam logic [1:0] CFG_HEAD_DELAY = 2'd2;
	localparam logic [1:0] CFG_BYTE_DELAY = 2'd3;

	localparam logic [15:0] SIDE_LEN_RST   = 16'd65500;
	localparam logic [15:0] HEAD_DELAY_RST = 16'd50000;
	localparam logic [7:0]  BYTE_DELAY_RST = 8'd149;

	localparam logic [15:0] CRC_POLY = 16'h8408;
	localparam logic [15:0] CRC_TOP  = 16'h8000;
	localparam logic [7:0]  STATUS_BUS_MASK = 8'h2C;
	localparam logic [7:0]  DRIVE_BUS_MASK  = 8'hF8;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] reg_addr;
		logic [7:0] write_value;
		logic [7:0] disk_byte;
		logic [7:0] open_bus;
	} in_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        timer_irq;
		logic        disk_irq;
		logic [15:0] head_position;
		logic        disk_write_enable;
		logic [15:0] disk_write_address;
		logic [7:0]  disk_write_data;
		logic        mirroring_horizontal;
	} out_t;

	typedef struct packed {
		logic       tick;
		logic       wr_reload_lo;
		logic       wr_reload_hi;
		logic       wr_timer_ctl;
		logic       wr_regs_off;
		logic       wr_data;
		logic       wr_ctrl;
		logic       wr_ext;
		logic       rd_status;
		logic       rd_data;
		logic       regs_en;
		logic [7:0] wval;
		logic [7:0] dbyte;
	} cmd_t;

	typedef struct packed {
		logic irq_q;
		logic irq_d;
		logic enabled_q;
	} tmr_stat_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  ext;
		logic        complete;
		logic        scanning;
		logic        irq_d;
		logic [15:0] head_pos;
		logic        we;
		logic [15:0] wa;
		logic [7:0]  wd;
		logic        mirror;
	} xfer_stat_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] c;
		c = acc;
		for (int i = 0; i < 8; i++) begin
			c = {1'b0, c[15:1]} ^ (c[0] ? CRC_POLY : 16'h0000) ^ (b[i] ? CRC_TOP : 16'h0000);
		end
		return c;
	endfunction

endpackage

// ===== src/dattc_timer.sv =====
// Reload/repeat interrupt timer: state registers and per-transaction next-state logic.
// Depends on dattc_pkg (cmd_t, tmr_stat_t).

module dattc_timer import dattc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cmd_t      cmd,
	output tmr_stat_t stat
);

	logic [15:0] reload_q, reload_d;
	logic [15:0] count_q, count_d;
	logic        enabled_q, enabled_d;
	logic        repeat_q, repeat_d;
	logic        irq_q, irq_d;

	always_comb begin
		reload_d  = reload_q;
		count_d   = count_q;
		enabled_d = enabled_q;
		repeat_d  = repeat_q;
		irq_d     = irq_q;
		if (cmd.tick && enabled_q) begin
			if (count_q == 16'd0) begin
				irq_d   = 1'b1;
				count_d = reload_q;
				if (!repeat_q) begin
					enabled_d = 1'b0;
				end
			end else begin
				count_d = count_q - 16'd1;
			end
		end
		if (cmd.wr_reload_lo) begin
			reload_d = {reload_q[15:8], cmd.wval};
		end
		if (cmd.wr_reload_hi) begin
			reload_d = {cmd.wval, reload_q[7:0]};
		end
		if (cmd.wr_timer_ctl) begin
			repeat_d  = cmd.wval[0];
			enabled_d = cmd.wval[1] & cmd.regs_en;
			if (cmd.wval[1] & cmd.regs_en) begin
				count_d = reload_q;
			end else begin
				irq_d = 1'b0;
			end
		end
		if (cmd.wr_regs_off) begin
			enabled_d = 1'b0;
			irq_d     = 1'b0;
		end
		if (cmd.rd_status) begin
			irq_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= '0;
			count_q   <= '0;
			enabled_q <= 1'b0;
			repeat_q  <= 1'b0;
			irq_q     <= 1'b0;
		end else begin
			reload_q  <= reload_d;
			count_q   <= count_d;
			enabled_q <= enabled_d;
			repeat_q  <= repeat_d;
			irq_q     <= irq_d;
		end
	end

	assign stat.irq_q     = irq_q;
	assign stat.irq_d     = irq_d;
	assign stat.enabled_q = enabled_q;

endmodule

// ===== src/dattc_xfer.sv =====
// Disk transfer engine: control/data registers, head position, delays, gap detect and CRC.
// Depends on dattc_pkg (cmd_t, xfer_stat_t, crc_feed).

module dattc_xfer import dattc_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  logic        disk_inserted,
	input  logic [15:0] side_length,
	input  logic [15:0] head_start_delay,
	input  logic [7:0]  byte_delay,
	output xfer_stat_t  stat
);

	localparam int TF_END_HEAD = 0;
	localparam int TF_SCANNING = 1;
	localparam int TF_GAP_END  = 2;
	localparam int TF_COMPLETE = 3;
	localparam int TF_PREV_CRC = 4;

	logic [7:0]               ctrl_q, ctrl_d;
	logic [7:0]               wdata_q, wdata_d;
	logic [7:0]               rdata_q, rdata_d;
	logic [7:0]               ext_q, ext_d;
	logic [4:0]               flags_q, flags_d;
	logic [15:0]              delay_q, delay_d;
	logic [POSITION_BITS-1:0] pos_q, pos_d;
	logic [15:0]              crc_q, crc_d;
	logic                     irq_q, irq_d;
	logic                     we;
	logic [15:0]              wa;
	logic [7:0]               wd;
	logic [7:0]               data;
	logic                     need_irq;
	logic                     crc_ctl;
	logic                     ready;

	always_comb begin
		ctrl_d   = ctrl_q;
		wdata_d  = wdata_q;
		rdata_d  = rdata_q;
		ext_d    = ext_q;
		flags_d  = flags_q;
		delay_d  = delay_q;
		pos_d    = pos_q;
		crc_d    = crc_q;
		irq_d    = irq_q;
		we       = 1'b0;
		wa       = '0;
		wd       = '0;
		data     = '0;
		need_irq = ctrl_q[7];
		crc_ctl  = ctrl_q[4];
		ready    = ctrl_q[6];

		if (cmd.tick) begin
			if (!disk_inserted || !ctrl_q[0]) begin
				flags_d[TF_END_HEAD] = 1'b1;
				flags_d[TF_SCANNING] = 1'b0;
			end else if (ctrl_q[1] && !flags_q[TF_SCANNING]) begin
				flags_d = flags_q;
			end else if (flags_q[TF_END_HEAD]) begin
				delay_d              = head_start_delay;
				flags_d[TF_END_HEAD] = 1'b0;
				flags_d[TF_GAP_END]  = 1'b0;
				pos_d                = '0;
			end else if (delay_q != 16'd0) begin
				delay_d = delay_q - 16'd1;
			end else begin
				flags_d[TF_SCANNING] = 1'b1;
				if (ctrl_q[2]) begin
					data = cmd.dbyte;
					if (!flags_q[TF_PREV_CRC]) begin
						crc_d = crc_feed(crc_q, data);
					end
					if (!ready) begin
						flags_d[TF_GAP_END] = 1'b0;
						crc_d               = '0;
					end else if ((data != 8'd0) && !flags_q[TF_GAP_END]) begin
						flags_d[TF_GAP_END] = 1'b1;
						need_irq            = 1'b0;
					end
					if (flags_d[TF_GAP_END]) begin
						flags_d[TF_COMPLETE] = 1'b1;
						rdata_d              = data;
						if (need_irq) begin
							irq_d = 1'b1;
						end
					end
				end else begin
					if (!crc_ctl) begin
						flags_d[TF_COMPLETE] = 1'b1;
						data                 = wdata_q;
						if (need_irq) begin
							irq_d = 1'b1;
						end
					end
					if (!ready) begin
						data = '0;
					end
					if (!crc_ctl) begin
						crc_d = crc_feed(crc_q, data);
					end else begin
						if (!flags_q[TF_PREV_CRC]) begin
							crc_d = crc_feed(crc_feed(crc_q, 8'h00), 8'h00);
						end
						data  = crc_d[7:0];
						crc_d = {8'h00, crc_d[15:8]};
					end
					if (pos_q >= POSITION_BITS'(2)) begin
						we = 1'b1;
						wa = 16'(pos_q - POSITION_BITS'(2));
						wd = data;
					end
					flags_d[TF_GAP_END] = 1'b0;
				end
				flags_d[TF_PREV_CRC] = crc_ctl;
				pos_d = pos_q + POSITION_BITS'(1);
				if (pos_d >= POSITION_BITS'(side_length)) begin
					ctrl_d[0] = 1'b0;
				end else begin
					delay_d = {8'h00, byte_delay};
				end
			end
		end

		if (cmd.wr_data) begin
			wdata_d              = cmd.wval;
			flags_d[TF_COMPLETE] = 1'b0;
			irq_d                = 1'b0;
		end
		if (cmd.wr_ctrl) begin
			ctrl_d = cmd.wval;
			irq_d  = 1'b0;
		end
		if (cmd.wr_ext) begin
			ext_d = cmd.wval;
		end
		if (cmd.wr_regs_off) begin
			irq_d = 1'b0;
		end
		if (cmd.rd_status || cmd.rd_data) begin
			flags_d[TF_COMPLETE] = 1'b0;
			irq_d                = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= '0;
			wdata_q <= '0;
			rdata_q <= '0;
			ext_q   <= '0;
			flags_q <= '0;
			delay_q <= '0;
			pos_q   <= '0;
			crc_q   <= '0;
			irq_q   <= 1'b0;
		end else begin
			ctrl_q  <= ctrl_d;
			wdata_q <= wdata_d;
			rdata_q <= rdata_d;
			ext_q   <= ext_d;
			flags_q <= flags_d;
			delay_q <= delay_d;
			pos_q   <= pos_d;
			crc_q   <= crc_d;
			irq_q   <= irq_d;
		end
	end

	assign stat.read_data = rdata_q;
	assign stat.ext       = ext_q;
	assign stat.complete  = flags_q[TF_COMPLETE];
	assign stat.scanning  = flags_q[TF_SCANNING];
	assign stat.irq_d     = irq_d;
	assign stat.head_pos  = pos_d[15:0];
	assign stat.we        = we;
	assign stat.wa        = wa;
	assign stat.wd        = wd;
	assign stat.mirror    = ctrl_d[3];

endmodule

// ===== src/disk_adapter_timer_and_transfer_core.sv =====
// Disk adapter register block: one transaction (bus write, bus read or CPU tick) per cycle
// while the output keeps up. An accepted transaction sits in an input register, passes
// once through the timer and transfer logic, and its result lands in the output register
// when that register is free or being read; a new transaction is taken every cycle while
// the output side keeps up. The throughput figure is set by that single combinational pass
// of timer, register decode and disk transfer between the two registers. Configuration
// writes are taken in every cycle and apply to the transactions that pass the transfer
// logic after the write.
// Depends on dattc_pkg, dattc_timer and dattc_xfer.

module disk_adapter_timer_and_transfer_core import dattc_pkg::*; #(
	parameter int POSITION_BITS = POSITION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic        valid_s1;
	in_t         txn_s1;
	logic        out_valid_q;
	out_t        out_q;
	logic        adv;
	logic        regs_en_q, regs_en_d;
	logic        inserted_q;
	logic [15:0] side_len_q;
	logic [15:0] head_delay_q;
	logic [7:0]  byte_delay_q;
	logic        is_wr, is_rd;
	logic [7:0]  rd_val;
	cmd_t        cmd;
	tmr_stat_t   tmr;
	xfer_stat_t  xs;
	out_t        res;

	assign adv       = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign is_wr = adv && (txn_s1.mode == MODE_WRITE);
	assign is_rd = adv && (txn_s1.mode == MODE_READ);

	always_comb begin
		cmd.tick         = adv && (txn_s1.mode == MODE_TICK);
		cmd.wr_reload_lo = is_wr && (txn_s1.reg_addr == REG_RELOAD_LO);
		cmd.wr_reload_hi = is_wr && (txn_s1.reg_addr == REG_RELOAD_HI);
		cmd.wr_timer_ctl = is_wr && (txn_s1.reg_addr == REG_TIMER_CTL);
		cmd.wr_regs_off  = is_wr && (txn_s1.reg_addr == REG_ENABLE) && !txn_s1.write_value[0];
		cmd.wr_data      = is_wr && regs_en_q && (txn_s1.reg_addr == REG_WDATA);
		cmd.wr_ctrl      = is_wr && regs_en_q && (txn_s1.reg_addr == REG_CONTROL);
		cmd.wr_ext       = is_wr && regs_en_q && (txn_s1.reg_addr == REG_EXT_OUT);
		cmd.rd_status    = is_rd && regs_en_q && (txn_s1.reg_addr == REG_STATUS);
		cmd.rd_data      = is_rd && regs_en_q && (txn_s1.reg_addr == REG_RDATA);
		cmd.regs_en      = regs_en_q;
		cmd.wval         = txn_s1.write_value;
		cmd.dbyte        = txn_s1.disk_byte;
	end

	assign regs_en_d = (is_wr && (txn_s1.reg_addr == REG_ENABLE)) ? txn_s1.write_value[0]
		: regs_en_q;

	always_comb begin
		rd_val = txn_s1.open_bus;
		if (regs_en_q) begin
			case (txn_s1.reg_addr)
				REG_STATUS: rd_val = (txn_s1.open_bus & STATUS_BUS_MASK)
					| {6'd0, xs.complete, tmr.irq_q};
				REG_RDATA:  rd_val = xs.read_data;
				REG_DRIVE: begin
					rd_val = txn_s1.open_bus & DRIVE_BUS_MASK;
					if (!inserted_q) begin
						rd_val = rd_val | 8'h07;
					end else if (!xs.scanning) begin
						rd_val = rd_val | 8'h02;
					end
				end
				REG_EXT_IN: rd_val = xs.ext;
				default:    rd_val = txn_s1.open_bus;
			endcase
		end
	end

	always_comb begin
		res.read_data            = (txn_s1.mode == MODE_READ) ? rd_val : txn_s1.open_bus;
		res.timer_irq            = tmr.irq_d;
		res.disk_irq             = xs.irq_d;
		res.head_position        = xs.head_pos;
		res.disk_write_enable    = xs.we;
		res.disk_write_address   = xs.wa;
		res.disk_write_data      = xs.wd;
		res.mirroring_horizontal = xs.mirror;
	end

	dattc_timer u_timer (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.stat   (tmr)
	);

	dattc_xfer #(
		.POSITION_BITS (POSITION_BITS)
	) u_xfer (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.disk_inserted    (inserted_q),
		.side_length      (side_len_q),
		.head_start_delay (head_delay_q),
		.byte_delay       (byte_delay_q),
		.stat             (xs)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			regs_en_q    <= 1'b0;
			inserted_q   <= 1'b0;
			side_len_q   <= SIDE_LEN_RST;
			head_delay_q <= HEAD_DELAY_RST;
			byte_delay_q <= BYTE_DELAY_RST;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			regs_en_q <= regs_en_d;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_INSERTED:   inserted_q   <= cfg_data[0];
					CFG_SIDE_LEN:   side_len_q   <= cfg_data;
					CFG_HEAD_DELAY: head_delay_q <= cfg_data;
					CFG_BYTE_DELAY: byte_delay_q <= cfg_data[7:0];
					default:        inserted_q   <= inserted_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			txn_s1 <= in_data;
		end
		if (adv) begin
			out_q <= res;
		end
	end

`ifndef NO_ASSERTIONS
	a_write_behind_head: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.disk_write_enable
		|-> (out_data.head_position - out_data.disk_write_address) == 16'd3)
		else $error("disk write address not two behind the pre-tick head position");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |-> !in_ready)
		else $error("input register overwritten while holding a transaction");

	a_timer_needs_regs: assert property (@(posedge clk) disable iff (!arst_n)
		!regs_en_q |-> !tmr.enabled_q)
		else $error("timer running while disk registers are disabled");
`endif

endmodule
